// ===== hw/rtl/lsrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Looping sample ring buffer package
// Request, result and configuration types, operation codes, register indexes
// and datapath widths shared by the front, back and remainder units.
// ----------------------------------------------------------------------------
package lsrb_pkg;

	localparam int LW = 17;	// length and end register width
	localparam int SW = 16;	// start register width
	localparam int NW = 18;	// remainder dividend width
	localparam int DW = 32;	// sample word width

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_SEEK  = 2'd2;

	localparam logic [1:0] REG_BUFFER_LENGTH = 2'd0;
	localparam logic [1:0] REG_LOOP_START    = 2'd1;
	localparam logic [1:0] REG_LOOP_END      = 2'd2;

	typedef struct packed {
		logic [1:0]    operation;
		logic [DW-1:0] sample;
		logic [SW-1:0] seek_position;
	} item_t;

	typedef struct packed {
		logic [DW-1:0] sample_out;
		logic          region_error;
	} result_t;

	typedef struct packed {
		logic [LW-1:0] len;
		logic [SW-1:0] loop_start;
		logic [LW-1:0] loop_end;
	} cfg_t;

	typedef struct packed {
		logic          start;
		logic [NW-1:0] dividend;
		logic [LW-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic          done;
		logic [LW-1:0] result;
	} rem_rsp_t;

endpackage

// ===== hw/rtl/looping_sample_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// Looping sample ring buffer
// Sample store with a wrapping write position and a looping read region.
// ----------------------------------------------------------------------------
// After reset the store is cleared to zero, one word a cycle, and no request is
// taken during the clear; configuration writes are taken at any time. A seek is
// carried out in the idle state, and so is a write, except when a stale write
// position needs a full remainder. A read goes through one shared remainder unit
// that returns one quotient bit a cycle, and skips the iteration when the
// dividend is already below the divisor; a read needs up to seven remainders. An
// empty region is flagged straight from the idle state, or after one remainder
// when it wraps. Requests queue two deep ahead of the back end and a finished
// result waits in the output register while the next request is carried out.
module looping_sample_ring_buffer #(
	parameter int CAPACITY = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  lsrb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output lsrb_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [16:0]       cfg_data
);
	import lsrb_pkg::*;

	localparam int         LEN_CLAMP         = (CAPACITY < 131071) ? CAPACITY : 131071;

	logic [LW-1:0] buffer_length_q;
	logic [SW-1:0] loop_start_q;
	logic [LW-1:0] loop_end_q;
	cfg_t          cfg;
	logic          clearing;
	logic          cmd_valid;
	item_t         cmd;
	logic          cmd_pop;
	rem_req_t      rem_req;
	rem_rsp_t      rem_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= LW'(65536);
			loop_start_q    <= '0;
			loop_end_q      <= LW'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BUFFER_LENGTH: buffer_length_q <= cfg_data;
				REG_LOOP_START:    loop_start_q    <= cfg_data[SW-1:0];
				REG_LOOP_END:      loop_end_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (buffer_length_q == '0) begin
			cfg.len = LW'(1);
		end else if (buffer_length_q > LW'(LEN_CLAMP)) begin
			cfg.len = LW'(LEN_CLAMP);
		end else begin
			cfg.len = buffer_length_q;
		end
		cfg.loop_start = loop_start_q;
		cfg.loop_end   = loop_end_q;
	end

	lsrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	lsrb_rem u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (rem_req),
		.rsp   (rem_rsp)
	);

	lsrb_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.clearing    (clearing),
		.rem_req     (rem_req),
		.rem_rsp     (rem_rsp),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	a_no_accept_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) clearing |-> !item_ready
	) else $error("request accepted during store clear");

	a_error_gives_zero: assert property (
		@(posedge clk) disable iff (!arst_n)
		result_valid && result.region_error |-> result.sample_out == '0
	) else $error("empty region result carries a sample");

	a_pop_needs_entry: assert property (
		@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid
	) else $error("queue popped while empty");

	a_one_remainder_at_a_time: assert property (
		@(posedge clk) disable iff (!arst_n) rem_req.start |=> !rem_req.start
	) else $error("remainder started twice in a row");

endmodule

// ===== hw/rtl/lsrb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/lsrb_rem.sv =====
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Unsigned remainder, one dividend bit per cycle; a dividend below the
// divisor is returned without iterating.
// ----------------------------------------------------------------------------
module lsrb_rem (
	input  logic               clk,
	input  logic               arst_n,
	input  lsrb_pkg::rem_req_t req,
	output lsrb_pkg::rem_rsp_t rsp
);
	import lsrb_pkg::*;

	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] dvd_q;
	logic [LW-1:0] div_q;
	logic [LW-1:0] rem_q;
	logic [LW:0]   trial;
	logic [LW:0]   diff;
	logic          ge;

	assign trial = {rem_q, dvd_q[NW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				div_q <= req.divisor;
				if (req.dividend < NW'(req.divisor)) begin
					rem_q  <= LW'(req.dividend);
					done_q <= 1'b1;
				end else begin
					dvd_q  <= req.dividend;
					rem_q  <= '0;
					cnt_q  <= CW'(NW - 1);
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= ge ? LW'(diff) : LW'(trial);
				dvd_q <= dvd_q << 1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = rem_q;

endmodule

// ===== hw/rtl/lsrb_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accept requests, drop unused operation codes and queue the rest, two deep.
// ----------------------------------------------------------------------------
module lsrb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  lsrb_pkg::item_t item,
	input  logic            clearing,
	output logic            cmd_valid,
	output lsrb_pkg::item_t cmd,
	input  logic            cmd_pop
);
	import lsrb_pkg::*;

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;

	assign keep = (item.operation == OP_WRITE) || (item.operation == OP_READ) ||
	              (item.operation == OP_SEEK);
	assign item_ready = !clearing && (cnt_q != 2'd2);
	assign push       = item_valid && item_ready && keep;
	assign cmd_valid  = cnt_q != 2'd0;
	assign cmd        = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/lsrb_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Clear the sample store, then carry out queued writes, reads and seeks.
// Folds the read position through the shared remainder unit.
// ----------------------------------------------------------------------------
module lsrb_back #(
	parameter int CAPACITY = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsrb_pkg::cfg_t     cfg,
	input  logic               cmd_valid,
	input  lsrb_pkg::item_t    cmd,
	output logic               cmd_pop,
	output logic               clearing,
	output lsrb_pkg::rem_req_t rem_req,
	input  lsrb_pkg::rem_rsp_t rem_rsp,
	output logic               result_valid,
	input  logic               result_ready,
	output lsrb_pkg::result_t  result
);
	import lsrb_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int PW = (CAPACITY > 65536) ? 17 : 16;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_WAIT,
		ST_GAP_WAIT,
		ST_FOLD,
		ST_FOLD_A_WAIT,
		ST_FOLD_B_WAIT,
		ST_FOLD_C_WAIT,
		ST_EMIT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic [LW-1:0] v_q;
	logic [LW-1:0] d_q;
	logic          sa_q;
	logic          neg_q;
	logic          second_q;
	logic          err_q;
	rem_req_t      rem_req_q;
	logic          result_valid_q;
	result_t       result_q;

	logic [LW-1:0] len;
	logic [LW-1:0] s17;
	logic [NW-1:0] len18;
	logic [NW-1:0] s18;
	logic [NW-1:0] wp_inc;
	logic [NW-1:0] vv;
	logic          fold_sa;
	logic [NW-1:0] fold_mag;
	logic [LW-1:0] m2;
	logic          c_neg;
	logic [NW-1:0] c_mag;
	logic [LW-1:0] f;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [DW-1:0] ram_rdata;

	assign len    = cfg.len;
	assign s17    = LW'(cfg.loop_start);
	assign len18  = NW'(len);
	assign s18    = NW'(cfg.loop_start);
	assign wp_inc = NW'(wp_q) + NW'(1);

	assign vv       = (v_q < len) ? NW'(v_q) + len18 : NW'(v_q);
	assign fold_sa  = vv < s18;
	assign fold_mag = fold_sa ? s18 - vv : vv - s18;

	assign m2 = rem_rsp.result;
	always_comb begin
		c_neg = 1'b0;
		if (!sa_q) begin
			c_mag = NW'(m2) + s18;
		end else if (m2 > s17) begin
			c_neg = 1'b1;
			c_mag = NW'(m2 - s17);
		end else begin
			c_mag = NW'(s17 - m2);
		end
	end

	assign f = (neg_q && (rem_rsp.result != '0)) ? len - rem_rsp.result : rem_rsp.result;

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign clearing = (state_q == ST_CLEAR);

	assign ram_we    = clearing || (cmd_pop && (cmd.operation == OP_WRITE));
	assign ram_waddr = clearing ? clr_q : AW'(wp_q);
	assign ram_wdata = clearing ? '0 : cmd.sample;
	assign ram_re    = (state_q == ST_FOLD_C_WAIT) && rem_rsp.done && !second_q;

	lsrb_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(AW'(f)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			rp_q           <= '0;
			wp_q           <= '0;
			v_q            <= '0;
			d_q            <= '0;
			sa_q           <= 1'b0;
			neg_q          <= 1'b0;
			second_q       <= 1'b0;
			err_q          <= 1'b0;
			rem_req_q      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready && (state_q != ST_EMIT)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(CAPACITY - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.operation)
							OP_WRITE: begin
								if (wp_inc < len18) begin
									wp_q <= PW'(wp_inc);
								end else if (wp_inc == len18) begin
									wp_q <= '0;
								end else begin
									rem_req_q <= '{start: 1'b1, dividend: wp_inc, divisor: len};
									state_q   <= ST_WR_WAIT;
								end
							end
							OP_READ: begin
								v_q      <= LW'(rp_q);
								second_q <= 1'b0;
								err_q    <= (cfg.loop_end == s17);
								if (cfg.loop_end == s17) begin
									state_q <= ST_EMIT;
								end else if (cfg.loop_end > s17) begin
									d_q     <= cfg.loop_end - s17;
									state_q <= ST_FOLD;
								end else begin
									rem_req_q <= '{start: 1'b1,
									               dividend: NW'(s17 - cfg.loop_end),
									               divisor: len};
									state_q   <= ST_GAP_WAIT;
								end
							end
							OP_SEEK: begin
								rp_q <= PW'(cmd.seek_position);
							end
							default: begin
							end
						endcase
					end
				end
				ST_WR_WAIT: begin
					if (rem_rsp.done) begin
						wp_q    <= PW'(rem_rsp.result);
						state_q <= ST_IDLE;
					end else begin
						rem_req_q.start <= 1'b0;
					end
				end
				ST_GAP_WAIT: begin
					if (rem_rsp.done) begin
						if (rem_rsp.result == '0) begin
							err_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							d_q     <= len - rem_rsp.result;
							state_q <= ST_FOLD;
						end
					end else begin
						rem_req_q.start <= 1'b0;
					end
				end
				ST_FOLD: begin
					sa_q      <= fold_sa;
					rem_req_q <= '{start: 1'b1, dividend: fold_mag, divisor: len};
					state_q   <= ST_FOLD_A_WAIT;
				end
				ST_FOLD_A_WAIT: begin
					if (rem_rsp.done) begin
						rem_req_q <= '{start: 1'b1, dividend: NW'(rem_rsp.result), divisor: d_q};
						state_q   <= ST_FOLD_B_WAIT;
					end else begin
						rem_req_q.start <= 1'b0;
					end
				end
				ST_FOLD_B_WAIT: begin
					if (rem_rsp.done) begin
						neg_q     <= c_neg;
						rem_req_q <= '{start: 1'b1, dividend: c_mag, divisor: len};
						state_q   <= ST_FOLD_C_WAIT;
					end else begin
						rem_req_q.start <= 1'b0;
					end
				end
				ST_FOLD_C_WAIT: begin
					if (rem_rsp.done) begin
						if (!second_q) begin
							v_q      <= f + LW'(1);
							second_q <= 1'b1;
							state_q  <= ST_FOLD;
						end else begin
							rp_q    <= PW'(f);
							state_q <= ST_EMIT;
						end
					end else begin
						rem_req_q.start <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q          <= 1'b1;
						result_q.sample_out     <= err_q ? '0 : ram_rdata;
						result_q.region_error   <= err_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rem_req      = rem_req_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Looping sample ring buffer testbench
// Sends write, read, seek and unused-code requests with random idling on both
// sides and keeps its own copy of the sample store, the two positions and the
// loop region. Each read result is checked in order against that copy. Register
// settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
	import lsrb_pkg::*;

	localparam int CAPACITY    = 65536;
	localparam int SETTLE      = 64;
	localparam int STALL_LIMIT = 300000;
	localparam int HOLD_CYCLES = 2000;

	localparam logic [1:0] OP_NONE        = 2'd3;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	item_t       item         = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index    = '0;
	logic [16:0] cfg_data     = '0;

	looping_sample_ring_buffer #(.CAPACITY(CAPACITY)) DUT (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	logic [16:0]  len_reg   = 17'd65536;
	logic [15:0]  start_reg = '0;
	logic [16:0]  end_reg   = 17'd65536;
	logic [15:0]  rd_pos    = '0;
	logic [15:0]  wr_pos    = '0;
	bit   [31:0]  stored_samples [CAPACITY];
	result_t      awaited_reads [$];
	item_t        request_queue [$];

	int requests_queued = 0, requests_taken = 0, failures = 0;
	int n_writes = 0, n_reads = 0, n_seeks = 0, n_empty = 0, settings_run = 0;
	int send_gap = 0, recv_stall = 0, hold_off = 0, quiet_cycles = 0;
	int sender_idle_max = 0, receiver_idle_max = 0;
	bit hold_armed = 1'b0;

	function automatic longint slots_in_use();
		if (len_reg == 0)
			return 1;
		if (len_reg > CAPACITY)
			return CAPACITY;
		return longint'(len_reg);
	endfunction

	function automatic bit fold_into_loop(input longint v, output longint folded);
		longint n, s, e, r, k;
		n = slots_in_use();
		s = longint'(start_reg);
		e = longint'(end_reg);
		if (e < s) begin
			k = (s - e + n - 1) / n;
			e += k * n;
		end
		if (e == s)
			return 1'b0;
		if (v < n)
			v += n;
		r = (v - s) % n;
		r = r % (e - s);
		r = (r + s) % n;
		if (r < 0)
			r += n;
		folded = r;
		return 1'b1;
	endfunction

	function automatic void predict_request(input item_t req);
		longint here, next_pos;
		result_t outcome;
		case (req.operation)
			OP_WRITE: begin
				stored_samples[wr_pos] = req.sample;
				wr_pos = 16'((longint'(wr_pos) + 1) % slots_in_use());
				n_writes++;
			end
			OP_READ: begin
				n_reads++;
				if (fold_into_loop(longint'(rd_pos), here) &&
						fold_into_loop(here + 1, next_pos)) begin
					outcome.sample_out = stored_samples[here];
					outcome.region_error = 1'b0;
					rd_pos = 16'(next_pos);
				end else begin
					outcome = '0;
					outcome.region_error = 1'b1;
					n_empty++;
				end
				awaited_reads.push_back(outcome);
			end
			OP_SEEK: begin
				rd_pos = req.seek_position;
				n_seeks++;
			end
			default: ;
		endcase
	endfunction

	// sender: hold until accepted, then idle for the drawn gap
	always @(posedge clk) begin
		if (arst_n && !(item_valid && !item_ready)) begin
			if (item_valid)
				send_gap = $urandom_range(0, sender_idle_max);
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (request_queue.size() != 0) begin
				item_valid <= 1'b1;
				item <= request_queue.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: stall after each result, once for a long stretch when armed
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				recv_stall = $urandom_range(0, receiver_idle_max);
				if (hold_armed) begin
					hold_off = HOLD_CYCLES;
					hold_armed = 1'b0;
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				result_ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t due;
		if (item_valid && item_ready) begin
			requests_taken++;
			predict_request(item);
		end
		if (result_valid && result_ready) begin
			if (awaited_reads.size() == 0) begin
				$error("result with no read outstanding: sample_out %h region_error %b",
					result.sample_out, result.region_error);
				failures++;
			end else begin
				due = awaited_reads.pop_front();
				if (result.sample_out !== due.sample_out) begin
					$error("sample_out: expected %h, got %h", due.sample_out, result.sample_out);
					failures++;
				end
				if (result.region_error !== due.region_error) begin
					$error("region_error: expected %b, got %b", due.region_error,
						result.region_error);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no request or result moved for %0d cycles", quiet_cycles);
				$display("looping_sample_ring_buffer: mismatch");
				$finish;
			end
		end
	end

	task automatic write_register(input logic [1:0] reg_index, input logic [16:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (reg_index)
			REG_BUFFER_LENGTH: len_reg = value;
			REG_LOOP_START:    start_reg = value[15:0];
			REG_LOOP_END:      end_reg = value;
			default: ;
		endcase
	endtask

	function automatic void offer(input logic [1:0] op, input logic [31:0] word,
			input logic [15:0] pos);
		item_t req;
		req.operation = op;
		req.sample = word;
		req.seek_position = pos;
		request_queue.push_back(req);
		requests_queued++;
	endfunction

	task automatic configure(input logic [16:0] len_v, input logic [16:0] start_v,
			input logic [16:0] end_v);
		write_register(REG_BUFFER_LENGTH, len_v);
		write_register(REG_LOOP_START, start_v);
		write_register(REG_LOOP_END, end_v);
		settings_run++;
		sender_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
		receiver_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
	endtask

	task automatic drain();
		while (requests_taken != requests_queued || awaited_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input logic [16:0] len_v, input logic [16:0] start_v,
			input logic [16:0] end_v, input int count, input bit squeeze);
		int unsigned pick, reach;
		logic [1:0] op;
		logic [15:0] pos;
		configure(len_v, start_v, end_v);
		reach = 32'((2 * slots_in_use() + 2 > 65535) ? 65535 : 2 * slots_in_use() + 2);
		if (squeeze) begin
			sender_idle_max = 0;
			hold_armed = 1'b1;
		end
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < (squeeze ? 10 : 40))
				op = OP_WRITE;
			else if (pick < (squeeze ? 95 : 80))
				op = OP_READ;
			else if (pick < 97)
				op = OP_SEEK;
			else
				op = OP_NONE;
			pos = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
				$urandom_range(0, reach));
			offer(op, $urandom, pos);
		end
		drain();
	endtask

	initial begin
		int unsigned l, s, e;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		offer(OP_READ, 32'h0, 16'h0);
		offer(OP_WRITE, 32'hFFFF_FFFF, 16'h0);
		offer(OP_WRITE, 32'h0000_0000, 16'hFFFF);
		offer(OP_WRITE, 32'hA5A5_A5A5, 16'h0);
		offer(OP_WRITE, 32'h5A5A_5A5A, 16'h0);
		offer(OP_SEEK, 32'h0, 16'h0);
		offer(OP_READ, 32'h0, 16'h0);
		offer(OP_READ, 32'h0, 16'h0);
		offer(OP_READ, 32'h0, 16'h0);
		offer(OP_SEEK, 32'hFFFF_FFFF, 16'hFFFF);
		offer(OP_READ, 32'h0, 16'h0);
		offer(OP_READ, 32'h0, 16'h0);
		offer(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF);
		drain();

		// shrink below the write position
		configure(17'd2, 17'd0, 17'd2);
		offer(OP_WRITE, 32'h1234_5678, 16'h0);
		offer(OP_WRITE, 32'h9ABC_DEF0, 16'h0);
		offer(OP_SEEK, 32'h0, 16'd4);
		offer(OP_READ, 32'h0, 16'h0);
		offer(OP_READ, 32'h0, 16'h0);
		drain();

		configure(17'd8, 17'd3, 17'd3);
		offer(OP_READ, 32'h0, 16'h0);
		offer(OP_WRITE, 32'hDEAD_BEEF, 16'h0);
		offer(OP_SEEK, 32'h0, 16'd6);
		offer(OP_READ, 32'h0, 16'h0);
		drain();

		run_phase(17'd0, 17'd0, 17'd1, 60, 1'b0);
		run_phase(17'd131071, 17'd65535, 17'd0, 60, 1'b0);
		run_phase(17'd16, 17'd12, 17'd4, 120, 1'b0);
		run_phase(17'd8, 17'd2, 17'd131071, 120, 1'b0);
		run_phase(17'd5, 17'd3, 17'd3, 60, 1'b0);
		run_phase(17'd32, 17'd65535, 17'd7, 100, 1'b0);
		run_phase(17'd12, 17'd0, 17'd12, 100, 1'b1);
		for (int p = 0; p < 6; p++) begin
			l = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) : $urandom_range(1, 64);
			s = $urandom_range(0, (l > 65531) ? 65535 : l + 4);
			e = $urandom_range(0, (l + 4 > 131071) ? 131071 : l + 4);
			run_phase(l[16:0], s[16:0], e[16:0], 100, 1'b0);
		end

		if (awaited_reads.size() != 0) begin
			$error("%0d read results never arrived", awaited_reads.size());
			failures++;
		end
		$display("Checked %0d reads (%0d on an empty loop region) against %0d writes and %0d seeks,",
			n_reads, n_empty, n_writes, n_seeks);
		$display("over %0d register settings with random idling and one long result hold-off.",
			settings_run);
		if (failures == 0)
			$display("looping_sample_ring_buffer: match");
		else
			$display("looping_sample_ring_buffer: mismatch");
		$finish;
	end

endmodule
